// File: sv/rfa_pkg.sv
// rational fraction alu package: widths, status and operation codes, command struct
// no dependencies
package rfa_pkg;
  localparam int WORD_BITS = 32;
  localparam int WIDE_BITS = 64;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // datapath micro-operations
  localparam logic [3:0] DP_NOP      = 4'd0;
  localparam logic [3:0] DP_LOAD     = 4'd1;  // take input, x=|a_num| y=|a_den|
  localparam logic [3:0] DP_GCD_STEP = 4'd2;  // one binary gcd step on x,y
  localparam logic [3:0] DP_DIV_INIT = 4'd3;  // start quotient p/g
  localparam logic [3:0] DP_DIV_STEP = 4'd4;  // one restoring division bit
  localparam logic [3:0] DP_STORE    = 4'd5;  // quotient to destination slot
  localparam logic [3:0] DP_SETUP    = 4'd6;  // load gcd operands for next phase
  localparam logic [3:0] DP_MUL_INIT = 4'd7;
  localparam logic [3:0] DP_MUL_STEP = 4'd8;  // one 32x32 partial product step
  localparam logic [3:0] DP_ADD      = 4'd9;
  localparam logic [3:0] DP_FINISH   = 4'd10;

  // phase selectors for setup/store/div/mul
  localparam logic [3:0] SEL_AN  = 4'd0;   // a numerator
  localparam logic [3:0] SEL_AD  = 4'd1;
  localparam logic [3:0] SEL_BN  = 4'd2;
  localparam logic [3:0] SEL_BD  = 4'd3;
  localparam logic [3:0] SEL_G   = 4'd4;   // lcm gcd: ta=bd/g
  localparam logic [3:0] SEL_G2  = 4'd5;   // tb=ad/g
  localparam logic [3:0] SEL_RN  = 4'd6;
  localparam logic [3:0] SEL_RD  = 4'd7;
  localparam logic [3:0] SEL_M1  = 4'd8;   // am*ta or am*bm
  localparam logic [3:0] SEL_M2  = 4'd9;   // bm*tb or ad*bd
  localparam logic [3:0] SEL_M3  = 4'd10;  // tb*bd
  localparam logic [3:0] SEL_ALT = 4'd11;  // b setup

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] sel;   // phase selector for setup/store/div/mul
  } dp_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic mul_done;
    logic zero_den;
    logic is_addsub;
  } dp_stat_t;
endpackage

// File: sv/rfa_datapath.sv
// rational fraction alu datapath: operand registers, binary gcd, divider, multiplier
// depends on rfa_pkg
module rfa_datapath (
  input  logic                  clk,
  input  rfa_pkg::dp_cmd_t      cmd,
  input  logic [1:0]            operation,
  input  logic [31:0]           a_num,
  input  logic [31:0]           a_den,
  input  logic [31:0]           b_num,
  input  logic [31:0]           b_den,
  output rfa_pkg::dp_stat_t     stat,
  output logic [31:0]           res_num,
  output logic [30:0]           res_den,
  output logic [1:0]            status
);
  localparam int W = rfa_pkg::WORD_BITS;
  localparam int D = rfa_pkg::WIDE_BITS;

  // sel codes
  localparam logic [3:0] S_AN = rfa_pkg::SEL_AN;
  localparam logic [3:0] S_AD = rfa_pkg::SEL_AD;
  localparam logic [3:0] S_BN = rfa_pkg::SEL_BN;
  localparam logic [3:0] S_BD = rfa_pkg::SEL_BD;
  localparam logic [3:0] S_G  = rfa_pkg::SEL_G;
  localparam logic [3:0] S_G2 = rfa_pkg::SEL_G2;
  localparam logic [3:0] S_RN = rfa_pkg::SEL_RN;
  localparam logic [3:0] S_RD = rfa_pkg::SEL_RD;
  localparam logic [3:0] S_M1 = rfa_pkg::SEL_M1;
  localparam logic [3:0] S_M2 = rfa_pkg::SEL_M2;
  localparam logic [3:0] S_ALT = rfa_pkg::SEL_ALT;

  logic [1:0] op;
  logic [D-1:0] an, ad, bn, bd, ta, tb, p1, p2, rm, rd;
  logic a_neg, b_neg, r_neg;
  logic [D-1:0] x, y, g;
  logic [6:0] sh;
  logic [D-1:0] rem, dvd, dvs;
  logic [6:0] cnt;
  logic [D-1:0] macc, mb;
  logic [W-1:0] ma;
  logic [1:0] mcnt;
  logic zden;

  function automatic logic [D-1:0] fmag(input logic [31:0] v);
    logic [W-1:0] w;
    begin
      w = v[W-1:0];
      fmag = w[W-1] ? {{(D-W){1'b0}}, -w} : {{(D-W){1'b0}}, w};
    end
  endfunction

  logic [D-1:0] src_p;
  always_comb begin
    case (cmd.sel)
      S_AN:    src_p = an;
      S_AD:    src_p = ad;
      S_BN:    src_p = bn;
      S_BD:    src_p = bd;
      S_G:     src_p = bd;
      S_G2:    src_p = ad;
      S_RN:    src_p = rm;
      S_RD:    src_p = rd;
      default: src_p = an;
    endcase
  end

  logic [D:0] trial;
  assign trial = {rem[D-2:0], dvd[D-1]} - {1'b0, dvs};

  logic [W-1:0] pp_b;
  assign pp_b = mb[W-1:0];

  // full 64-bit partial product of two 32-bit halves
  logic [2*W-1:0] pp;
  assign pp = ma * pp_b;

  logic [D-1:0] gv;
  assign gv = (g == '0) ? {{(D-1){1'b0}}, 1'b1} : g;

  logic [D-1:0] lim;
  assign lim = {{(D-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic [D-1:0] sa, sb;
  logic bs;
  always_comb begin
    sa = p1;
    sb = p2;
    bs = (op == rfa_pkg::OP_SUB) ? !b_neg : b_neg;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rfa_pkg::DP_LOAD: begin
        op    <= operation;
        an    <= fmag(a_num);
        ad    <= fmag(a_den);
        bn    <= fmag(b_num);
        bd    <= fmag(b_den);
        a_neg <= a_num[W-1] ^ a_den[W-1];
        b_neg <= b_num[W-1] ^ b_den[W-1];
        zden  <= (a_den[W-1:0] == '0) || (b_den[W-1:0] == '0);
        x     <= fmag(a_num);
        y     <= fmag(a_den);
        sh    <= '0;
      end
      rfa_pkg::DP_SETUP: begin
        sh <= '0;
        case (cmd.sel)
          S_ALT:   begin x <= bn; y <= bd; end
          S_G:     begin x <= ad; y <= bd; end
          default: begin x <= rm; y <= rd; end
        endcase
      end
      rfa_pkg::DP_GCD_STEP: begin
        // stein: shared factors of two counted in sh
        if (x == '0) g <= y << sh;
        else if (y == '0) g <= x << sh;
        else if (!x[0] && !y[0]) begin x <= x >> 1; y <= y >> 1; sh <= sh + 7'd1; end
        else if (!x[0]) x <= x >> 1;
        else if (!y[0]) y <= y >> 1;
        else if (x >= y) x <= (x - y) >> 1;
        else y <= (y - x) >> 1;
      end
      rfa_pkg::DP_DIV_INIT: begin
        dvd <= src_p;
        dvs <= gv;
        rem <= '0;
        cnt <= '0;
      end
      rfa_pkg::DP_DIV_STEP: begin
        dvd <= {dvd[D-2:0], ~trial[D]};
        if (!trial[D]) rem <= trial[D-1:0];
        else rem <= {rem[D-2:0], dvd[D-1]};
        cnt <= cnt + 7'd1;
      end
      rfa_pkg::DP_STORE: begin
        case (cmd.sel)
          S_AN: an <= dvd;
          S_AD: ad <= (dvd == '0) ? {{(D-1){1'b0}}, 1'b1} : dvd;
          S_BN: bn <= dvd;
          S_BD: begin
            if (op == rfa_pkg::OP_DIV) begin
              // reciprocal of b, sign stays on the numerator
              bn <= (dvd == '0) ? {{(D-1){1'b0}}, 1'b1} : dvd;
              bd <= bn;
            end else begin
              bd <= (dvd == '0) ? {{(D-1){1'b0}}, 1'b1} : dvd;
            end
          end
          S_G:  ta <= dvd;
          S_G2: tb <= dvd;
          S_RN: rm <= dvd;
          default: rd <= (dvd == '0) ? {{(D-1){1'b0}}, 1'b1} : dvd;
        endcase
      end
      rfa_pkg::DP_MUL_INIT: begin
        macc <= '0;
        mcnt <= '0;
        case (cmd.sel)
          S_M1: begin
            ma <= an[W-1:0];
            mb <= (op[1]) ? bn : ta;
          end
          S_M2: begin
            ma <= (op[1]) ? ad[W-1:0] : bn[W-1:0];
            mb <= (op[1]) ? bd : tb;
          end
          default: begin ma <= tb[W-1:0]; mb <= bd; end
        endcase
      end
      rfa_pkg::DP_MUL_STEP: begin
        // multiplicand halves one at a time, 32x32 each
        macc <= macc + (pp << (mcnt[0] ? W : 0));
        mb   <= mb >> W;
        mcnt <= mcnt + 2'd1;
        if (mcnt == 2'd1) begin
          case (cmd.sel)
            S_M1:    p1 <= macc + (pp << W);
            S_M2:    p2 <= macc + (pp << W);
            default: rd <= macc + (pp << W);
          endcase
          if (op[1] && cmd.sel == S_M2)
            rd <= macc + (pp << W);
          if (op[1] && cmd.sel == S_M1) begin
            rm    <= macc + (pp << W);
            r_neg <= a_neg ^ b_neg;
          end
        end
      end
      rfa_pkg::DP_ADD: begin
        if (a_neg == bs) begin rm <= sa + sb; r_neg <= a_neg; end
        else if (sa >= sb) begin rm <= sa - sb; r_neg <= a_neg; end
        else begin rm <= sb - sa; r_neg <= bs; end
      end
      rfa_pkg::DP_FINISH: begin
        if (zden) begin
          status <= rfa_pkg::ST_ZERO_DEN; res_num <= '0; res_den <= 31'd1;
        end else if (op == rfa_pkg::OP_DIV && bd == '0) begin
          // reciprocal of a zero fraction has a zero denominator
          status <= rfa_pkg::ST_DIV_ZERO; res_num <= '0; res_den <= 31'd1;
        end else if (rd > lim - 1 ||
                     ((r_neg && rm != '0) ? (rm > lim) : (rm > lim - 1))) begin
          status <= rfa_pkg::ST_OVERFLOW; res_num <= '0; res_den <= 31'd1;
        end else begin
          status  <= rfa_pkg::ST_OK;
          res_num <= (r_neg && rm != '0) ? 32'(-rm) : rm[31:0];
          res_den <= rd[30:0];
        end
      end
      default: ;
    endcase
  end

  assign stat.gcd_done  = (x == '0) || (y == '0);
  assign stat.div_done  = (cnt == 7'(D));
  assign stat.mul_done  = (mcnt == 2'd2);
  assign stat.zero_den  = zden;
  assign stat.is_addsub = !op[1];
endmodule

// File: sv/rfa_control.sv
// rational fraction alu controller: sequences the datapath phases per item
// depends on rfa_pkg
module rfa_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rfa_pkg::dp_stat_t stat,
  output rfa_pkg::dp_cmd_t  cmd
);
  localparam logic [3:0] C_IDLE  = 4'd0;
  localparam logic [3:0] C_CHECK = 4'd1;
  localparam logic [3:0] C_GCD   = 4'd2;
  localparam logic [3:0] C_DINIT = 4'd3;
  localparam logic [3:0] C_DIV   = 4'd4;
  localparam logic [3:0] C_STORE = 4'd5;
  localparam logic [3:0] C_NEXT  = 4'd6;
  localparam logic [3:0] C_MINIT = 4'd7;
  localparam logic [3:0] C_MUL   = 4'd8;
  localparam logic [3:0] C_ADD   = 4'd9;
  localparam logic [3:0] C_FIN   = 4'd10;
  localparam logic [3:0] C_OUT   = 4'd11;
  localparam logic [3:0] C_RSET  = 4'd12;
  localparam logic [3:0] C_FSET  = 4'd13;

  logic [3:0] state, state_next;
  logic [3:0] slot, slot_next;   // which quotient is being formed
  logic [3:0] mslot, mslot_next;

  assign in_stall  = (state != C_IDLE) || out_valid;

  always_comb begin
    state_next = state;
    slot_next  = slot;
    mslot_next = mslot;
    cmd.op  = rfa_pkg::DP_NOP;
    cmd.sel = slot;
    unique case (state)
      C_IDLE: if (in_valid && !out_valid) begin
        cmd.op = rfa_pkg::DP_LOAD;
        slot_next = rfa_pkg::SEL_AN;
        state_next = C_CHECK;
      end
      C_CHECK: state_next = stat.zero_den ? C_FIN : C_GCD;
      C_GCD: begin
        cmd.op = rfa_pkg::DP_GCD_STEP;
        if (stat.gcd_done) state_next = C_DINIT;
      end
      C_DINIT: begin cmd.op = rfa_pkg::DP_DIV_INIT; state_next = C_DIV; end
      C_DIV: begin
        if (stat.div_done) state_next = C_STORE;
        else cmd.op = rfa_pkg::DP_DIV_STEP;
      end
      C_STORE: begin
        cmd.op = rfa_pkg::DP_STORE;
        state_next = C_NEXT;
      end
      C_NEXT: begin
        // slots pair up: num/den of a, of b, lcm multipliers, result
        case (slot) inside
          rfa_pkg::SEL_AN, rfa_pkg::SEL_BN, rfa_pkg::SEL_G, rfa_pkg::SEL_RN: begin
            slot_next = slot + 4'd1; state_next = C_DINIT;
          end
          rfa_pkg::SEL_AD: begin
            cmd.op = rfa_pkg::DP_SETUP; cmd.sel = rfa_pkg::SEL_ALT;
            slot_next = rfa_pkg::SEL_BN; state_next = C_GCD;
          end
          rfa_pkg::SEL_BD: begin
            if (stat.is_addsub) begin
              cmd.op = rfa_pkg::DP_SETUP; cmd.sel = rfa_pkg::SEL_G;
              slot_next = rfa_pkg::SEL_G; state_next = C_GCD;
            end else begin
              mslot_next = rfa_pkg::SEL_M1; state_next = C_MINIT;
            end
          end
          rfa_pkg::SEL_G2: begin mslot_next = rfa_pkg::SEL_M1; state_next = C_MINIT; end
          default: state_next = C_FIN;
        endcase
      end
      C_MINIT: begin
        cmd.op = rfa_pkg::DP_MUL_INIT; cmd.sel = mslot; state_next = C_MUL;
      end
      C_MUL: begin
        cmd.sel = mslot;
        if (stat.mul_done) begin
          if (!stat.is_addsub && mslot == rfa_pkg::SEL_M2) state_next = C_RSET;
          else if (mslot == rfa_pkg::SEL_M3) state_next = C_ADD;
          else begin mslot_next = mslot + 4'd1; state_next = C_MINIT; end
        end else cmd.op = rfa_pkg::DP_MUL_STEP;
      end
      C_ADD: begin cmd.op = rfa_pkg::DP_ADD; state_next = C_RSET; end
      C_RSET: begin
        cmd.op = rfa_pkg::DP_SETUP; cmd.sel = rfa_pkg::SEL_RN;
        slot_next = rfa_pkg::SEL_RN; state_next = C_GCD;
      end
      C_FIN: begin cmd.op = rfa_pkg::DP_FINISH; state_next = C_OUT; end
      C_OUT: state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE; slot <= '0; mslot <= rfa_pkg::SEL_M1; out_valid <= 1'b0;
    end else begin
      state <= state_next; slot <= slot_next; mslot <= mslot_next;
      if (state == C_FIN) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != C_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_after_fin: assert property (@(posedge clk) disable iff (rst)
    (state == C_FIN) |=> out_valid) else $error("result lost");
  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    (state == C_OUT) |=> (state == C_IDLE)) else $error("bad sequence");
`endif
endmodule

// File: sv/rational_fraction_alu.sv
// rational fraction alu: add, subtract, multiply, divide of signed fractions
// one item at a time. in_valid/in_stall take an operation and two fractions;
// out_valid/out_stall return reduced res_num/res_den and status.
// latency is data dependent: each gcd runs one binary step a cycle, each
// reduction divides one quotient bit a cycle, and products are built from
// two 32x32 partial products. the gcd and divide units are shared by all
// phases of an item; a zero denominator skips all of it and goes from the
// input check straight to the finish step.
// status 1 is a zero denominator, 2 division by a zero fraction, 3 overflow;
// on an error the result is 0/1.
// the next item is taken once the previous result has been handed over.
// a stalled result holds its value until taken. synchronous reset returns the
// controller to idle with no result pending.
module rational_fraction_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output logic [1:0]  status
);
  rfa_pkg::dp_cmd_t  cmd;
  rfa_pkg::dp_stat_t stat;

  rfa_control u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  rfa_datapath u_dp (
    .clk, .cmd, .operation, .a_num, .a_den, .b_num, .b_den, .stat,
    .res_num, .res_den, .status
  );
endmodule
